[design/ihss_pkg.sv]
// shared codes, byte constants and helper functions for the image header size sniffer
`default_nettype none

package ihss_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned DIM_W    = 32;
	localparam int unsigned FMT_W    = 2;
	localparam int unsigned CHAN_W   = 2;

	typedef logic [FMT_W-1:0] fmt_t;

	localparam fmt_t FMT_NONE = 2'd0;
	localparam fmt_t FMT_JPEG = 2'd1;
	localparam fmt_t FMT_PNG  = 2'd2;

	localparam logic [CHAN_W-1:0] CHANNELS = 2'd3;

	localparam logic [DATA_W-1:0] BYTE_FF  = 8'hFF;
	localparam logic [DATA_W-1:0] JPEG_SOI = 8'hD8;
	localparam logic [DATA_W-1:0] PNG_SIG0 = 8'h89;
	localparam logic [DATA_W-1:0] PNG_SIG1 = 8'h50;

	// png signature byte by position within the first eight bytes
	function automatic logic [DATA_W-1:0] png_sig_byte(input logic [2:0] idx);
		logic [DATA_W-1:0] v;
		case (idx)
			3'd0: v = 8'h89;
			3'd1: v = 8'h50;
			3'd2: v = 8'h4E;
			3'd3: v = 8'h47;
			3'd4: v = 8'h0D;
			3'd5: v = 8'h0A;
			3'd6: v = 8'h1A;
			default: v = 8'h0A;
		endcase
		return v;
	endfunction

	// chunk name of the first png chunk
	function automatic logic [DATA_W-1:0] ihdr_byte(input logic [1:0] idx);
		logic [DATA_W-1:0] v;
		case (idx)
			2'd0: v = 8'h49;
			2'd1: v = 8'h48;
			2'd2: v = 8'h44;
			default: v = 8'h52;
		endcase
		return v;
	endfunction

	// start-of-frame markers: c0..cf except dht, jpg and dac
	function automatic logic is_frame_marker(input logic [DATA_W-1:0] m);
		return (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
	endfunction

endpackage

`default_nettype wire

[design/image_header_size_sniffer_unit.sv]
// image header size sniffer: byte-stream jpeg/png header parser, one result per buffer
`default_nettype none
// a byte accepted into the input register is parsed from there by the parse state update,
// and a result it yields is loaded into the output register by the same edge
// throughput: one byte per cycle while out_stall is low; the parse state update of one
// byte is the only loop
// reset: arst_n clears the parse state and both valid flags; after a last_byte
// transaction the parser is back in its reset state for the next buffer
module image_header_size_sniffer_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [ihss_pkg::DATA_W-1:0]   data_byte,
	input  wire                           last_byte,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [ihss_pkg::FMT_W-1:0]    image_format,
	output logic [ihss_pkg::DIM_W-1:0]    image_height,
	output logic [ihss_pkg::DIM_W-1:0]    image_width,
	output logic [ihss_pkg::CHAN_W-1:0]   channel_count
);
	import ihss_pkg::*;

	// parse phase codes
	localparam logic [3:0] PH_SIG     = 4'd0;
	localparam logic [3:0] PH_PNG     = 4'd1;
	localparam logic [3:0] PH_JSCAN   = 4'd2;
	localparam logic [3:0] PH_JMARK   = 4'd3;
	localparam logic [3:0] PH_JLENHI  = 4'd4;
	localparam logic [3:0] PH_JLENLO  = 4'd5;
	localparam logic [3:0] PH_JSKIP   = 4'd6;
	localparam logic [3:0] PH_JSOFPAD = 4'd7;
	localparam logic [3:0] PH_JSOFDIM = 4'd8;
	localparam logic [3:0] PH_DEAD    = 4'd9;

	localparam logic [4:0] POS_MAX = 5'd24;

	// input register stage
	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              last_s1;

	// parser state
	logic [3:0]        phase_q;
	logic [4:0]        pos_q;
	fmt_t              fmt_q;
	logic [15:0]       skip_q;
	logic [7:0]        len_hi_q;
	logic [63:0]       dim_q;
	logic              sent_q;

	// result register
	logic              out_valid_q;
	fmt_t              fmt_out_q;
	logic [DIM_W-1:0]  height_out_q;
	logic [DIM_W-1:0]  width_out_q;
	logic [CHAN_W-1:0] chan_out_q;

	// next-state and result logic
	logic [3:0]        phase_d;
	logic [4:0]        pos_d;
	fmt_t              fmt_d;
	logic [15:0]       skip_d;
	logic [7:0]        len_hi_d;
	logic [63:0]       dim_d;
	logic              sent_d;
	logic              res_hit;
	fmt_t              res_fmt;
	logic [DIM_W-1:0]  res_height;
	logic [DIM_W-1:0]  res_width;
	logic [CHAN_W-1:0] res_chan;
	logic              emit;
	logic [15:0]       seg_len;
	logic [63:0]       dim_shift;
	logic [15:0]       skip_dec;
	logic              advance;

	// stage 1 moves on when the output register is free or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	assign seg_len   = {len_hi_q, byte_s1};
	assign dim_shift = {dim_q[55:0], byte_s1};
	assign skip_dec  = skip_q - 16'd1;

	always_comb begin
		phase_d    = phase_q;
		fmt_d      = fmt_q;
		skip_d     = skip_q;
		len_hi_d   = len_hi_q;
		dim_d      = dim_q;
		sent_d     = sent_q;
		res_hit    = 1'b0;
		res_fmt    = FMT_NONE;
		res_height = '0;
		res_width  = '0;
		res_chan   = '0;

		unique case (phase_q)
			PH_SIG: begin
				if (pos_q == 5'd0) begin
					if (byte_s1 == BYTE_FF) begin
						fmt_d = FMT_JPEG;
					end else if (byte_s1 == PNG_SIG0) begin
						fmt_d = FMT_PNG;
					end else begin
						fmt_d   = FMT_NONE;
						phase_d = PH_DEAD;
					end
				end else if (pos_q == 5'd1 && fmt_q == FMT_JPEG && byte_s1 == JPEG_SOI) begin
					phase_d = PH_JSCAN;
				end else if (pos_q == 5'd1 && fmt_q == FMT_PNG && byte_s1 == PNG_SIG1) begin
					phase_d = PH_PNG;
				end else begin
					fmt_d   = FMT_NONE;
					phase_d = PH_DEAD;
				end
			end
			PH_PNG: begin
				if (pos_q < 5'd8) begin
					if (byte_s1 != png_sig_byte(pos_q[2:0])) begin
						fmt_d   = FMT_NONE;
						phase_d = PH_DEAD;
					end
				end else if (pos_q >= 5'd12 && pos_q < 5'd16) begin
					if (byte_s1 != ihdr_byte(pos_q[1:0])) begin
						fmt_d   = FMT_NONE;
						phase_d = PH_DEAD;
					end
				end else if (pos_q >= 5'd16 && pos_q < POS_MAX) begin
					dim_d = dim_shift;
					if (pos_q == 5'd23) begin
						// width comes first in the ihdr chunk
						res_hit    = 1'b1;
						res_fmt    = FMT_PNG;
						res_height = dim_shift[31:0];
						res_width  = dim_shift[63:32];
						res_chan   = CHANNELS;
						sent_d     = 1'b1;
						phase_d    = PH_DEAD;
					end
				end
			end
			PH_JSCAN: begin
				if (byte_s1 == BYTE_FF) begin
					phase_d = PH_JMARK;
				end
			end
			PH_JMARK: begin
				if (is_frame_marker(byte_s1)) begin
					skip_d  = 16'd3;
					phase_d = PH_JSOFPAD;
				end else begin
					phase_d = PH_JLENHI;
				end
			end
			PH_JLENHI: begin
				len_hi_d = byte_s1;
				phase_d  = PH_JLENLO;
			end
			PH_JLENLO: begin
				// the length counts its own two bytes
				if (seg_len < 16'd3) begin
					skip_d  = '0;
					phase_d = PH_JSCAN;
				end else begin
					skip_d  = seg_len - 16'd2;
					phase_d = PH_JSKIP;
				end
			end
			PH_JSKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) begin
					phase_d = PH_JSCAN;
				end
			end
			PH_JSOFPAD: begin
				// segment length and precision sit ahead of the size
				skip_d = skip_dec;
				if (skip_dec == 16'd0) begin
					skip_d  = 16'd4;
					dim_d   = '0;
					phase_d = PH_JSOFDIM;
				end
			end
			PH_JSOFDIM: begin
				dim_d  = dim_shift;
				skip_d = skip_dec;
				if (skip_dec == 16'd0) begin
					res_hit    = 1'b1;
					res_fmt    = FMT_JPEG;
					res_height = {16'd0, dim_shift[31:16]};
					res_width  = {16'd0, dim_shift[15:0]};
					res_chan   = CHANNELS;
					sent_d     = 1'b1;
					phase_d    = PH_DEAD;
				end
			end
			default: begin
				// ignoring phase and unused codes hold still
			end
		endcase

		pos_d = (pos_q < POS_MAX) ? pos_q + 5'd1 : POS_MAX;

		// a buffer that ends without a size still gives an empty result
		emit = res_hit || (last_s1 && !sent_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// parser state, cleared by reset and after the last byte of each buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIG;
			pos_q    <= '0;
			fmt_q    <= FMT_NONE;
			skip_q   <= '0;
			len_hi_q <= '0;
			dim_q    <= '0;
			sent_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				phase_q  <= PH_SIG;
				pos_q    <= '0;
				fmt_q    <= FMT_NONE;
				skip_q   <= '0;
				len_hi_q <= '0;
				dim_q    <= '0;
				sent_q   <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				fmt_q    <= fmt_d;
				skip_q   <= skip_d;
				len_hi_q <= len_hi_d;
				dim_q    <= dim_d;
				sent_q   <= sent_d;
			end
		end
	end

	// output register: loaded only when the previous result has left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			fmt_out_q    <= res_fmt;
			height_out_q <= res_height;
			width_out_q  <= res_width;
			chan_out_q   <= res_chan;
		end
	end

	assign out_valid     = out_valid_q;
	assign image_format  = fmt_out_q;
	assign image_height  = height_out_q;
	assign image_width   = width_out_q;
	assign channel_count = chan_out_q;

`ifndef SYNTHESIS
	// once a size is reported the rest of the buffer is ignored
	a_sent_dead: assert property (@(posedge clk) disable iff (!arst_n)
		sent_q |-> phase_q == PH_DEAD)
		else $error("result sent but parser not in ignoring phase");

	// byte counter saturates
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte position beyond saturation");

	// an empty result carries no size, a found one always has three channels
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && image_format == FMT_NONE |->
		image_height == '0 && image_width == '0 && channel_count == '0)
		else $error("empty result with nonzero fields");

	a_found_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && image_format != FMT_NONE |-> channel_count == CHANNELS)
		else $error("found size without channel count");

	// a parsed last byte always leaves the parser in its reset state
	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && last_s1 |=> phase_q == PH_SIG && pos_q == '0 && !sent_q)
		else $error("parser not cleared after last byte");
`endif

endmodule

`default_nettype wire

[tb/sv/ihss_tb_pkg.sv]
// marker codes, png header constants and the size record shared by the sniffer testbench
package ihss_tb_pkg;

	localparam logic [3:0]  SOF_HI  = 4'hC;
	localparam logic [7:0]  MK_SOF0 = 8'hC0;
	localparam logic [7:0]  MK_DHT  = 8'hC4;
	localparam logic [7:0]  MK_JPG  = 8'hC8;
	localparam logic [7:0]  MK_DAC  = 8'hCC;
	localparam logic [7:0]  MK_RST0 = 8'hD0;
	localparam logic [7:0]  MK_APP0 = 8'hE0;

	// png signature and first chunk name, big-endian byte order
	localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
	localparam logic [31:0] IHDR_NAME = 32'h49484452;

	typedef struct packed {
		ihss_pkg::fmt_t                     fmt;
		logic [ihss_pkg::DIM_W-1:0]         height;
		logic [ihss_pkg::DIM_W-1:0]         width;
		logic [ihss_pkg::CHAN_W-1:0]        chans;
	} size_rec_t;

endpackage

[tb/sv/ihss_checker.sv]
// header size checker: follows the byte stream, predicts each size result and compares
module ihss_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	input  wire                           in_stall,
	input  wire  [ihss_pkg::DATA_W-1:0]   data_byte,
	input  wire                           last_byte,
	input  wire                           out_valid,
	input  wire                           out_stall,
	input  wire  [ihss_pkg::FMT_W-1:0]    image_format,
	input  wire  [ihss_pkg::DIM_W-1:0]    image_height,
	input  wire  [ihss_pkg::DIM_W-1:0]    image_width,
	input  wire  [ihss_pkg::CHAN_W-1:0]   channel_count,
	output logic [31:0]                   fail_count,
	output logic [31:0]                   open_count
);
	import ihss_pkg::*;
	import ihss_tb_pkg::*;

	typedef enum logic [3:0] {
		SN_SIG, SN_PNG, SN_SCAN, SN_MARK, SN_LEN_HI, SN_LEN_LO,
		SN_SKIP, SN_SOF_PAD, SN_SOF_DIM, SN_DONE
	} sniff_phase_t;

	sniff_phase_t  phase_q;
	logic [4:0]    pos_q;
	fmt_t          fmt_q;
	logic [15:0]   remain_q;
	logic [7:0]    len_hi_q;
	logic [63:0]   shift_q;
	logic          sent_q;

	size_rec_t     expected_sizes[$];
	int            mismatches = 0;

	task automatic clear_parse();
		phase_q  = SN_SIG;
		pos_q    = '0;
		fmt_q    = FMT_NONE;
		remain_q = '0;
		len_hi_q = '0;
		shift_q  = '0;
		sent_q   = 1'b0;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
		mismatches++;
	endtask

	// one byte through the header parser; got is set when it yields a result
	task automatic sniff_byte(input logic [7:0] b, input logic fin, output bit got,
			output size_rec_t rec);
		logic [4:0]  p;
		logic [15:0] seg_len;
		p   = pos_q;
		got = 1'b0;
		rec = '0;
		case (phase_q)
			SN_SIG: begin
				if (p == 5'd0) begin
					if (b == BYTE_FF)
						fmt_q = FMT_JPEG;
					else if (b == PNG_SIG0)
						fmt_q = FMT_PNG;
					else begin
						fmt_q   = FMT_NONE;
						phase_q = SN_DONE;
					end
				end else if (p == 5'd1 && fmt_q == FMT_JPEG && b == JPEG_SOI) begin
					phase_q = SN_SCAN;
				end else if (p == 5'd1 && fmt_q == FMT_PNG && b == PNG_SIG1) begin
					phase_q = SN_PNG;
				end else begin
					fmt_q   = FMT_NONE;
					phase_q = SN_DONE;
				end
			end
			SN_PNG: begin
				if (p < 5'd8) begin
					if (b != PNG_MAGIC[63 - 8 * p[2:0] -: 8]) begin
						fmt_q   = FMT_NONE;
						phase_q = SN_DONE;
					end
				end else if (p >= 5'd12 && p < 5'd16) begin
					if (b != IHDR_NAME[31 - 8 * p[1:0] -: 8]) begin
						fmt_q   = FMT_NONE;
						phase_q = SN_DONE;
					end
				end else if (p >= 5'd16 && p < 5'd24) begin
					shift_q = {shift_q[55:0], b};
					if (p == 5'd23) begin
						got        = 1'b1;
						rec.fmt    = FMT_PNG;
						rec.height = shift_q[31:0];
						rec.width  = shift_q[63:32];
						rec.chans  = CHANNELS;
						sent_q     = 1'b1;
						phase_q    = SN_DONE;
					end
				end
			end
			SN_SCAN: begin
				if (b == BYTE_FF)
					phase_q = SN_MARK;
			end
			SN_MARK: begin
				if (b[7:4] == SOF_HI && b != MK_DHT && b != MK_JPG && b != MK_DAC) begin
					remain_q = 16'd3;
					phase_q  = SN_SOF_PAD;
				end else begin
					phase_q = SN_LEN_HI;
				end
			end
			SN_LEN_HI: begin
				len_hi_q = b;
				phase_q  = SN_LEN_LO;
			end
			SN_LEN_LO: begin
				seg_len  = {len_hi_q, b};
				remain_q = (seg_len < 16'd2) ? 16'd0 : seg_len - 16'd2;
				phase_q  = (remain_q != 16'd0) ? SN_SKIP : SN_SCAN;
			end
			SN_SKIP: begin
				remain_q = remain_q - 16'd1;
				if (remain_q == 16'd0)
					phase_q = SN_SCAN;
			end
			SN_SOF_PAD: begin
				remain_q = remain_q - 16'd1;
				if (remain_q == 16'd0) begin
					remain_q = 16'd4;
					shift_q  = '0;
					phase_q  = SN_SOF_DIM;
				end
			end
			SN_SOF_DIM: begin
				shift_q  = {shift_q[55:0], b};
				remain_q = remain_q - 16'd1;
				if (remain_q == 16'd0) begin
					got        = 1'b1;
					rec.fmt    = FMT_JPEG;
					rec.height = {16'd0, shift_q[31:16]};
					rec.width  = {16'd0, shift_q[15:0]};
					rec.chans  = CHANNELS;
					sent_q     = 1'b1;
					phase_q    = SN_DONE;
				end
			end
			default: ;
		endcase
		pos_q = (p < 5'd24) ? p + 5'd1 : 5'd24;
		if (fin) begin
			// nothing found in this buffer: all-zero result
			if (!got && !sent_q) begin
				got = 1'b1;
				rec = '0;
			end
			clear_parse();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		bit        got;
		size_rec_t rec;
		size_rec_t want;
		if (!arst_n) begin
			clear_parse();
			expected_sizes.delete();
			open_count <= '0;
			fail_count <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				sniff_byte(data_byte, last_byte, got, rec);
				if (got)
					expected_sizes.push_back(rec);
			end
			if (out_valid && !out_stall) begin
				if (expected_sizes.size() == 0) begin
					report_mismatch("result with none expected, format",
						32'(image_format), 32'(FMT_NONE));
				end else begin
					want = expected_sizes.pop_front();
					if (image_format != want.fmt)
						report_mismatch("image_format", 32'(image_format), 32'(want.fmt));
					if (image_height != want.height)
						report_mismatch("image_height", image_height, want.height);
					if (image_width != want.width)
						report_mismatch("image_width", image_width, want.width);
					if (channel_count != want.chans)
						report_mismatch("channel_count", 32'(channel_count),
							32'(want.chans));
				end
			end
			open_count <= 32'(expected_sizes.size());
			fail_count <= 32'(mismatches);
		end
	end

endmodule

[tb/sv/tb_image_header_size_sniffer_unit.sv]
// top of the sniffer testbench: byte stimulus, output stall, checker hookup and verdict
module tb_image_header_size_sniffer_unit;
	import ihss_pkg::*;
	import ihss_tb_pkg::*;

	// which side leaves gaps: receiver-heavy first, then sender-heavy, then none
	typedef enum int {GAPS_RECV_HEAVY, GAPS_SEND_HEAVY, GAPS_NONE} gap_mode_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic [DATA_W-1:0]      data_byte = '0;
	logic                   last_byte = 1'b0;
	logic                   out_stall = 1'b0;
	wire                    in_stall;
	wire                    out_valid;
	wire  [FMT_W-1:0]       image_format;
	wire  [DIM_W-1:0]       image_height;
	wire  [DIM_W-1:0]       image_width;
	wire  [CHAN_W-1:0]      channel_count;
	logic [31:0]            fail_count;
	logic [31:0]            open_count;

	gap_mode_t              gap_mode   = GAPS_RECV_HEAVY;
	int                     sent_bytes = 0;
	// bytes of the image buffer being built, sent in order with last on the final one
	logic [7:0]             image_buf[$];

	image_header_size_sniffer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.image_format  (image_format),
		.image_height  (image_height),
		.image_width   (image_width),
		.channel_count (channel_count)
	);

	// the checker sees both channels exactly as the block does
	ihss_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.image_format  (image_format),
		.image_height  (image_height),
		.image_width   (image_width),
		.channel_count (channel_count),
		.fail_count    (fail_count),
		.open_count    (open_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver stalls, a fresh coin every cycle so stalls land on every phase
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) <
			((gap_mode == GAPS_RECV_HEAVY) ? 45 : (gap_mode == GAPS_SEND_HEAVY) ? 7 : 0));
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#1000000;
		$display("== FAIL ==");
		$finish;
	end

	// one input transaction; idle cycles carry junk payload with valid low
	task automatic send_byte(input logic [7:0] b, input logic fin);
		bit taken;
		while ($urandom_range(0, 99) <
				((gap_mode == GAPS_RECV_HEAVY) ? 7 : (gap_mode == GAPS_SEND_HEAVY) ? 45 : 0)) begin
			in_valid  <= 1'b0;
			data_byte <= 8'($urandom);
			last_byte <= 1'($urandom);
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		// stall is stable between edges, so the mid-cycle sample decides the next edge
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		sent_bytes++;
	endtask

	task automatic send_image();
		for (int i = 0; i < image_buf.size(); i++)
			send_byte(image_buf[i], i == image_buf.size() - 1);
	endtask

	// well-formed png header with the given size and some bytes after it
	task automatic build_png(input logic [31:0] w, input logic [31:0] h, input int tail);
		image_buf.delete();
		for (int i = 0; i < 8; i++)
			image_buf.push_back(PNG_MAGIC[63 - 8 * i -: 8]);
		// chunk length is not looked at
		repeat (4) image_buf.push_back(8'($urandom));
		for (int i = 0; i < 4; i++)
			image_buf.push_back(IHDR_NAME[31 - 8 * i -: 8]);
		for (int i = 0; i < 4; i++)
			image_buf.push_back(w[31 - 8 * i -: 8]);
		for (int i = 0; i < 4; i++)
			image_buf.push_back(h[31 - 8 * i -: 8]);
		repeat (tail) image_buf.push_back(8'($urandom));
	endtask

	// jpeg: soi, a few random segments, then optionally a frame header with the size
	task automatic build_jpeg(input bit with_frame, input logic [15:0] h,
			input logic [15:0] w, input int tail);
		logic [7:0]  mk;
		logic [15:0] seg_len;
		int          pick;
		image_buf.delete();
		image_buf.push_back(BYTE_FF);
		image_buf.push_back(JPEG_SOI);
		repeat ($urandom_range(0, 3)) begin
			// stray non-ff bytes between segments are skipped by the scanner
			repeat ($urandom_range(0, 2)) image_buf.push_back(8'($urandom_range(0, 254)));
			image_buf.push_back(BYTE_FF);
			case ($urandom_range(0, 4))
				0: begin
					pick = $urandom_range(0, 2);
					mk   = (pick == 0) ? MK_DHT : (pick == 1) ? MK_JPG : MK_DAC;
				end
				1: mk = BYTE_FF;
				2: mk = MK_RST0 | 8'($urandom_range(0, 7));
				3: mk = MK_APP0 | 8'($urandom_range(0, 15));
				default: mk = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'hBF)) :
					8'($urandom_range(8'hD0, 8'hFF));
			endcase
			image_buf.push_back(mk);
			case ($urandom_range(0, 9))
				0: seg_len = 16'($urandom_range(0, 1));
				1: seg_len = 16'($urandom);
				default: seg_len = 16'($urandom_range(2, 10));
			endcase
			image_buf.push_back(seg_len[15:8]);
			image_buf.push_back(seg_len[7:0]);
			// long segment: the buffer ends somewhere inside it
			if (seg_len > 16'd12) begin
				repeat ($urandom_range(0, 5)) image_buf.push_back(8'($urandom));
				return;
			end
			for (int k = 2; k < seg_len; k++)
				image_buf.push_back(8'($urandom));
		end
		if (with_frame) begin
			repeat ($urandom_range(0, 2)) image_buf.push_back(8'($urandom_range(0, 254)));
			image_buf.push_back(BYTE_FF);
			do
				mk = {SOF_HI, 4'($urandom_range(0, 15))};
			while (mk == MK_DHT || mk == MK_JPG || mk == MK_DAC);
			image_buf.push_back(mk);
			// precision and the first length bytes before the dimensions
			repeat (3) image_buf.push_back(8'($urandom));
			image_buf.push_back(h[15:8]);
			image_buf.push_back(h[7:0]);
			image_buf.push_back(w[15:8]);
			image_buf.push_back(w[7:0]);
		end
		repeat (tail) image_buf.push_back(8'($urandom));
	endtask

	initial begin
		int kind;
		int cut;
		int spot;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown signature, buffer of a single byte
		image_buf = '{8'h00};
		send_image();
		// png with all-ones size, found on the last byte
		build_png(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_image();
		// jpeg: stray byte, ff fill marker with length 0, restart marker with length 1,
		// dht with one skipped ff, then sof0 with all-ones size and one dropped byte
		image_buf = '{BYTE_FF, JPEG_SOI, 8'h00, BYTE_FF, BYTE_FF, 8'h00, 8'h00,
			BYTE_FF, MK_RST0, 8'h00, 8'h01, BYTE_FF, MK_DHT, 8'h00, 8'h03, BYTE_FF,
			BYTE_FF, MK_SOF0, 8'h00, 8'h11, 8'h22, BYTE_FF, BYTE_FF, BYTE_FF, BYTE_FF,
			8'h00};
		send_image();
		// jpeg with no start of frame before the end
		image_buf = '{BYTE_FF, JPEG_SOI, 8'h12, BYTE_FF};
		send_image();

		while (sent_bytes < 1250) begin
			gap_mode <= (sent_bytes < 450) ? GAPS_RECV_HEAVY :
				(sent_bytes < 850) ? GAPS_SEND_HEAVY : GAPS_NONE;
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				build_jpeg(1'b1, 16'($urandom), 16'($urandom),
					$urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
			end else if (kind < 65) begin
				build_png($urandom, $urandom, $urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
			end else if (kind < 75) begin
				// jpeg cut short at a random byte
				build_jpeg(1'($urandom), 16'($urandom), 16'($urandom), 0);
				cut = $urandom_range(1, image_buf.size());
				while (image_buf.size() > cut)
					void'(image_buf.pop_back());
			end else if (kind < 85) begin
				// png with one header byte broken, or cut short
				build_png($urandom, $urandom, $urandom_range(0, 3));
				if ($urandom_range(0, 1)) begin
					spot = $urandom_range(0, 15);
					image_buf[spot] = image_buf[spot] ^ 8'($urandom_range(1, 255));
				end else begin
					cut = $urandom_range(1, image_buf.size());
					while (image_buf.size() > cut)
						void'(image_buf.pop_back());
				end
			end else if (kind < 92) begin
				build_jpeg(1'b0, 16'd0, 16'd0, $urandom_range(0, 3));
			end else begin
				// noise, sometimes with a plausible first byte
				image_buf.delete();
				repeat ($urandom_range(1, 6)) image_buf.push_back(8'($urandom));
				if ($urandom_range(0, 1))
					image_buf[0] = $urandom_range(0, 1) ? BYTE_FF : PNG_SIG0;
			end
			send_image();
		end
		in_valid <= 1'b0;

		// drain: every expected result out, then a few quiet cycles for strays
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
